// File: src/kvsv_pkg.sv
// ---------------------------------------------------------------------------
// kvsv_pkg
// Shared types and constants of the key/value string validator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvsv_pkg;

  // byte codes
  localparam logic [7:0] DELIM_CHAR = 8'd92;
  localparam logic [7:0] TERM_CHAR  = 8'd0;

  // reset value of the length limit
  localparam logic [7:0] MAX_LEN_RESET = 8'd128;

  typedef logic [7:0] char_t;
  typedef logic [7:0] len_t;
  typedef logic [2:0] phase_t;

  // parse phase codes
  localparam phase_t PH_START  = 3'd0;
  localparam phase_t PH_LEAD   = 3'd1;
  localparam phase_t PH_KEY    = 3'd2;
  localparam phase_t PH_VFIRST = 3'd3;
  localparam phase_t PH_VALUE  = 3'd4;
  localparam phase_t PH_VEND   = 3'd5;
  localparam phase_t PH_SKIP   = 3'd6;

  // registered input byte handed to the parser
  typedef struct packed {
    logic  valid;
    char_t char_byte;
  } in_item_t;

  // verdict handed to the output register
  typedef struct packed {
    logic valid;
    logic string_ok;
  } verdict_t;

endpackage

`default_nettype wire

// File: src/kvsv_if.sv
// ---------------------------------------------------------------------------
// kvsv_in_if / kvsv_out_if
// Valid/ready channels for input bytes and string verdicts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kvsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface kvsv_out_if;
  logic valid;
  logic ready;
  logic string_ok;

  modport source (output valid, output string_ok, input ready);
  modport sink (input valid, input string_ok, output ready);
endinterface

`default_nettype wire

// File: src/kvsv_in_stage.sv
// ---------------------------------------------------------------------------
// kvsv_in_stage
// Input register: captures one byte transaction per cycle while it is empty or its byte is being taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvsv_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  kvsv_in_if.sink                in_ch,
  input  wire logic              take,
  output kvsv_pkg::in_item_t     item
);
  import kvsv_pkg::*;

  logic  valid_r, valid_nxt;
  char_t char_r;
  logic  load;

  // register is free when empty or being consumed this cycle
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= in_ch.char_byte;
    end
  end

  assign item.valid     = valid_r;
  assign item.char_byte = char_r;

endmodule

`default_nettype wire

// File: src/kvsv_parser.sv
// ---------------------------------------------------------------------------
// kvsv_parser
// Key/value phase and length: one byte per cycle unless a terminator waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvsv_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,
  input  wire kvsv_pkg::in_item_t item,
  input  wire logic              out_free,
  output logic                   take,
  output kvsv_pkg::verdict_t     verdict
);
  import kvsv_pkg::*;

  len_t   max_len_r;
  phase_t phase_r, phase_nxt;
  len_t   len_r, len_nxt;
  logic   is_term;
  logic   is_delim;
  logic   can_begin;
  logic   can_extend;

  assign is_term  = (item.char_byte == TERM_CHAR);
  assign is_delim = (item.char_byte == DELIM_CHAR);

  // a terminator needs room in the output register
  assign take = item.valid && (!is_term || out_free);

  assign can_begin  = (max_len_r != 8'd0);
  assign can_extend = (len_r < max_len_r);

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // next phase and length
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    if (is_term) begin
      phase_nxt = PH_START;
      len_nxt   = 8'd0;
    end else begin
      case (phase_r)
        PH_START: begin
          if (is_delim) begin
            phase_nxt = PH_LEAD;
          end else if (can_begin) begin
            phase_nxt = PH_KEY;
            len_nxt   = 8'd1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_LEAD, PH_VEND: begin
          if (can_begin) begin
            phase_nxt = PH_KEY;
            len_nxt   = 8'd1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_KEY: begin
          if (is_delim) begin
            phase_nxt = PH_VFIRST;
          end else if (can_extend) begin
            len_nxt = len_r + 8'd1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_VFIRST: begin
          if (is_delim) begin
            phase_nxt = PH_SKIP;
          end else if (can_begin) begin
            phase_nxt = PH_VALUE;
            len_nxt   = 8'd1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_VALUE: begin
          if (is_delim) begin
            phase_nxt = PH_VEND;
          end else if (can_extend) begin
            len_nxt = len_r + 8'd1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      len_r   <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
    end
  end

  // verdict at the terminator
  assign verdict.valid     = take && is_term;
  assign verdict.string_ok = (phase_r == PH_VALUE) || (phase_r == PH_VEND);

endmodule

`default_nettype wire

// File: src/kvsv_out_stage.sv
// ---------------------------------------------------------------------------
// kvsv_out_stage
// Output register holding one verdict until the sink takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvsv_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kvsv_pkg::verdict_t verdict,
  output logic                   out_free,
  kvsv_out_if.source             out_ch
);
  import kvsv_pkg::*;

  logic valid_r, valid_nxt;
  logic ok_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (verdict.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (verdict.valid) begin
      ok_r <= verdict.string_ok;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.string_ok = ok_r;

endmodule

`default_nettype wire

// File: src/key_value_string_validator.sv
// A verdict appears on the output in the cycle after the parser takes its terminator.
// Throughput: one byte per cycle while no terminator is waiting, as below.
// A terminator waits in the input register only while a prior verdict is not taken.
// Reset (synchronous, rst_n low): phase to start of string, length 0,
// length limit 128, both stage registers empty.
// ---------------------------------------------------------------------------
// key_value_string_validator
// Checks backslash-delimited key/value strings and issues one verdict each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_value_string_validator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  kvsv_in_if.sink         in_ch,
  kvsv_out_if.source      out_ch
);
  import kvsv_pkg::*;

  in_item_t item;
  verdict_t verdict;
  logic     take;
  logic     out_free;

  // input register
  kvsv_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .item  (item)
  );

  // grammar tracking
  kvsv_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .out_free    (out_free),
    .take        (take),
    .verdict     (verdict)
  );

  // result register
  kvsv_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .verdict  (verdict),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
